@@ hw/rtl/tblh_pkg.sv @@
// Shared types, register codes and saturation helpers for the two-bead Heun step block.
package tblh_pkg;

  typedef logic signed [63:0] wide_t;

  // Internal force/drift values saturate at +-2^61 (Q.24 in 64 bits)
  localparam logic [63:0] SAT_LIMIT = 64'h2000_0000_0000_0000;
  localparam wide_t SAT_POS = 64'sh2000_0000_0000_0000;
  localparam wide_t SAT_NEG = -64'sh2000_0000_0000_0000;

  typedef enum logic [2:0] {
    CFG_WELL_COEFF   = 3'd0,
    CFG_WELL_MIN     = 3'd1,
    CFG_WELL_POWER   = 3'd2,
    CFG_REP_KIND     = 3'd3,
    CFG_REP_STRENGTH = 3'd4,
    CFG_DRIFT_ONE    = 3'd5,
    CFG_DRIFT_TWO    = 3'd6,
    CFG_TIME_STEP    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REP_NONE     = 3'd0,
    REP_CONST    = 3'd1,
    REP_LINEAR   = 3'd2,
    REP_INV_SQ   = 3'd3,
    REP_INV_CUBE = 3'd4
  } rep_kind_e;

  function automatic logic signed [31:0] sat_s32(input wide_t v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic wide_t sat_lim(input wide_t v);
    if (v > SAT_POS) begin
      return SAT_POS;
    end else if (v < SAT_NEG) begin
      return SAT_NEG;
    end
    return v;
  endfunction

  function automatic logic [63:0] mag64(input wide_t v);
    wide_t n;
    n = -v;
    return v[63] ? 64'(n) : 64'(v);
  endfunction

endpackage

@@ hw/rtl/two_bead_langevin_heun_step_top.sv @@
// Two-bead overdamped Langevin Heun integrator on a shared multiply/divide/root sequencer.
// One accepted noise beat advances both beads by one Heun step (force at the
// current positions, half step to a midpoint, force there, averaged drift plus
// full noise) and yields one result beat: new positions, elapsed time and the
// midpoint separation. All math is Q8.24 / Q16.16 fixed point with saturation.
// Work runs on one sequencer that drives a single 32x32 multiplier (high
// half, low half and combine states per scaled product), a restoring
// bit-serial divider whose step count depends on the operands and a 32-step
// integer square root. The work per item grows with the well power n and
// with the repulsion kind (none and constant cheapest, then linear, inverse
// square, inverse cube). in_ready_o is high only while the sequencer is
// idle; a finished result sits in the output registers and the next item
// can be taken meanwhile, but that item will not complete until the earlier
// result beat has been taken. Configuration writes are always accepted and
// must be made only while idle.
module two_bead_langevin_heun_step_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] noise_x_one_i,
  input  logic signed [31:0] noise_y_one_i,
  input  logic signed [31:0] noise_x_two_i,
  input  logic signed [31:0] noise_y_two_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_one_o,
  output logic signed [31:0] pos_y_one_o,
  output logic signed [31:0] pos_x_two_o,
  output logic signed [31:0] pos_y_two_o,
  output logic [31:0]        elapsed_time_o,
  output logic [31:0]        separation_o
);
  import tblh_pkg::*;

  // Divider step counts: numerator bits plus fraction bits
  localparam logic [6:0] DIV_RATIO = 7'd55;  // well_min (31b) << 24
  localparam logic [6:0] DIV_UNIT  = 7'd56;  // |dx| (32b) << 24
  localparam logic [6:0] DIV_INVSQ = 7'd90;  // k*|s| (34b) << 56
  localparam logic [6:0] DIV_CHAIN = 7'd86;  // prior quotient (62b) << 24

  typedef enum logic [4:0] {
    S_IDLE, S_DELTA, S_SQ_X, S_SQ_Y, S_ROOT, S_RATIO, S_POW, S_WELL,
    S_REP, S_REP_CUBE, S_REP_FIN, S_SUM, S_UNIT_X, S_DIR_X, S_UNIT_Y,
    S_DIR_Y, S_DRIFT, S_DRIFT_FIN, S_FINISH,
    S_MUL_HI, S_MUL_LO, S_MUL_END, S_DIV, S_SQRT
  } state_e;

  // Configuration registers
  logic [31:0]        coeff_q, drift1_q, drift2_q, tstep_q;
  logic [30:0]        wmin_q;
  logic [3:0]         wpow_q;
  logic [2:0]         rkind_q;
  logic signed [31:0] rstr_q;

  // Sequencer and architectural state
  state_e             state_q, ret_q;
  logic signed [31:0] pos_q [4];
  logic signed [31:0] ep_q [4];   // positions the force is evaluated at
  logic signed [31:0] np_q [4];   // new positions, held until the output frees
  logic signed [31:0] nz_q [4];
  wide_t              m1_q [4];   // first-stage drift
  logic [31:0]        time_q, sep_q, out_sep_q;
  logic               out_valid_q, stage_q;
  logic [1:0]         idx_q;

  // Force evaluation working registers
  logic signed [31:0] dx_q, dy_q;
  logic [31:0]        adx_q, ady_q, d_q, qr_q;
  logic [63:0]        d2_q, pw_q, lo_q;
  logic [4:0]         pw_cnt_q;
  wide_t              u_q, rep_q, tx_q, ty_q;

  // Multiplier unit: |a| split in two 32-bit halves times b
  logic [63:0]        mm_q, hb_q, lb_q;
  logic               mneg_q, msh16_q, mraw_q;
  logic [31:0]        mb_q;
  wide_t              mres_q;

  // Divider unit
  logic [63:0]        dv_num_q, dv_den_q, dv_rem_q, dv_quo_q, dres_q;
  logic               dv_sat_q;
  logic [6:0]         dv_cnt_q;

  // Square-root unit
  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;

  // ---------------- shared multiplier ----------------
  logic [31:0] mult_a;
  logic [63:0] mult_p;
  assign mult_a = (state_q == S_MUL_HI) ? mm_q[63:32] : mm_q[31:0];
  assign mult_p = {32'd0, mult_a} * {32'd0, mb_q};

  logic [63:0] mc_sum, mc_mag;
  logic        mc_sat;
  wide_t       mc_res;
  always_comb begin
    if (msh16_q) begin
      mc_sat = hb_q > (SAT_LIMIT >> 16);
      mc_sum = (hb_q << 16) + (lb_q >> 16);
    end else begin
      mc_sat = hb_q > (SAT_LIMIT >> 8);
      mc_sum = (hb_q << 8) + (lb_q >> 24);
    end
    if (mraw_q) begin
      mc_mag = lb_q;
    end else if (mc_sat || mc_sum > SAT_LIMIT) begin
      mc_mag = SAT_LIMIT;
    end else begin
      mc_mag = mc_sum;
    end
    mc_res = mneg_q ? -wide_t'(mc_mag) : wide_t'(mc_mag);
  end

  // ---------------- divider step ----------------
  logic [64:0] dv_shift, dv_diff;
  logic        dv_ge, dv_sat_n;
  logic [63:0] dv_rem_n, dv_quo_n, dv_fin;
  always_comb begin
    dv_shift = {dv_rem_q, dv_num_q[63]};
    dv_diff  = dv_shift - {1'b0, dv_den_q};
    dv_ge    = dv_shift >= {1'b0, dv_den_q};
    dv_rem_n = dv_ge ? dv_diff[63:0] : dv_shift[63:0];
    dv_quo_n = {dv_quo_q[62:0], dv_ge};
    dv_sat_n = dv_sat_q | dv_quo_q[63] | dv_quo_q[62];
    dv_fin   = (dv_sat_n || dv_quo_n > SAT_LIMIT) ? SAT_LIMIT : dv_quo_n;
  end

  // ---------------- square-root step ----------------
  logic [63:0] sq_t, sq_v_n, sq_res_n;
  always_comb begin
    sq_t = sq_res_q + sq_bit_q;
    if (sq_v_q >= sq_t) begin
      sq_v_n   = sq_v_q - sq_t;
      sq_res_n = (sq_res_q >> 1) + sq_bit_q;
    end else begin
      sq_v_n   = sq_v_q;
      sq_res_n = sq_res_q >> 1;
    end
  end

  // ---------------- misc datapath ----------------
  logic signed [32:0] ex_c, ey_c;
  logic signed [31:0] dx_c, dy_c;
  logic [31:0]        adx_c, ady_c, ratio_c, s_mag;
  logic [33:0]        s_mag3, s_mag2;
  wide_t              diff_c, f_sel, mid_c, fin_c, lin_c;
  logic [32:0]        time_sum;
  logic [31:0]        time_sat_c;

  always_comb begin
    ex_c  = 33'(ep_q[0]) - 33'(ep_q[2]);
    ey_c  = 33'(ep_q[1]) - 33'(ep_q[3]);
    dx_c  = sat_s32(64'(ex_c));
    dy_c  = sat_s32(64'(ey_c));
    adx_c = dx_c[31] ? (32'd0 - $unsigned(dx_c)) : $unsigned(dx_c);
    ady_c = dy_c[31] ? (32'd0 - $unsigned(dy_c)) : $unsigned(dy_c);

    ratio_c = (dres_q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : dres_q[31:0];
    // saturated high power stands for the whole difference
    diff_c  = (pw_q >= SAT_LIMIT) ? SAT_POS : (wide_t'(pw_q) - wide_t'(lo_q));

    s_mag  = rstr_q[31] ? (32'd0 - $unsigned(rstr_q)) : $unsigned(rstr_q);
    s_mag2 = {1'b0, s_mag, 1'b0};
    s_mag3 = {2'b0, s_mag} + s_mag2;
    lin_c  = mres_q >>> 15;

    case (idx_q)
      2'd0:    f_sel = -tx_q;
      2'd1:    f_sel = -ty_q;
      2'd2:    f_sel = tx_q;
      default: f_sel = ty_q;
    endcase
    mid_c = 64'(sat_s32(64'(pos_q[idx_q]) + ((mres_q + 64'(nz_q[idx_q])) >>> 1)));
    fin_c = 64'(sat_s32(64'(pos_q[idx_q]) + ((m1_q[idx_q] + mres_q) >>> 1)
                        + 64'(nz_q[idx_q])));

    time_sum   = {1'b0, time_q} + {1'b0, tstep_q};
    time_sat_c = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
  end

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q  <= 32'd786432;
      wmin_q   <= 31'd16777216;
      wpow_q   <= 4'd6;
      rkind_q  <= REP_NONE;
      rstr_q   <= '0;
      drift1_q <= 32'd65536;
      drift2_q <= 32'd65536;
      tstep_q  <= 32'd16777;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WELL_COEFF:   coeff_q  <= cfg_data_i;
        CFG_WELL_MIN:     wmin_q   <= cfg_data_i[30:0];
        CFG_WELL_POWER:   wpow_q   <= cfg_data_i[3:0];
        CFG_REP_KIND:     rkind_q  <= cfg_data_i[2:0];
        CFG_REP_STRENGTH: rstr_q   <= $signed(cfg_data_i);
        CFG_DRIFT_ONE:    drift1_q <= cfg_data_i;
        CFG_DRIFT_TWO:    drift2_q <= cfg_data_i;
        CFG_TIME_STEP:    tstep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  // A call to a shared unit loads its operands, parks the return state in
  // ret_q and jumps to the unit's states; the unit jumps back when done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      stage_q     <= 1'b0;
      idx_q       <= '0;
      time_q      <= '0;
      sep_q       <= '0;
      out_sep_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        pos_q[i] <= '0;
        ep_q[i]  <= '0;
        np_q[i]  <= '0;
        nz_q[i]  <= '0;
        m1_q[i]  <= '0;
      end
      dx_q <= '0; dy_q <= '0; adx_q <= '0; ady_q <= '0; d_q <= '0; qr_q <= '0;
      d2_q <= '0; pw_q <= '0; lo_q <= '0; pw_cnt_q <= '0;
      u_q <= '0; rep_q <= '0; tx_q <= '0; ty_q <= '0;
      mm_q <= '0; hb_q <= '0; lb_q <= '0; mneg_q <= 1'b0; msh16_q <= 1'b0;
      mraw_q <= 1'b0; mb_q <= '0; mres_q <= '0;
      dv_num_q <= '0; dv_den_q <= '0; dv_rem_q <= '0; dv_quo_q <= '0;
      dres_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= '0;
      sq_v_q <= '0; sq_res_q <= '0; sq_bit_q <= '0;
    end else begin
      // S_FINISH refills the slot itself when it commits on a taken beat
      if (out_valid_q && out_ready_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            nz_q[0] <= noise_x_one_i;
            nz_q[1] <= noise_y_one_i;
            nz_q[2] <= noise_x_two_i;
            nz_q[3] <= noise_y_two_i;
            for (int i = 0; i < 4; i++) ep_q[i] <= pos_q[i];
            stage_q <= 1'b0;
            state_q <= S_DELTA;
          end
        end
        S_DELTA: begin
          dx_q <= dx_c; dy_q <= dy_c; adx_q <= adx_c; ady_q <= ady_c;
          mm_q <= {32'd0, adx_c}; mb_q <= adx_c; mneg_q <= 1'b0; mraw_q <= 1'b1;
          ret_q <= S_SQ_X; state_q <= S_MUL_LO;
        end
        S_SQ_X: begin
          d2_q <= 64'(mres_q);
          mm_q <= {32'd0, ady_q}; mb_q <= ady_q; mneg_q <= 1'b0; mraw_q <= 1'b1;
          ret_q <= S_SQ_Y; state_q <= S_MUL_LO;
        end
        S_SQ_Y: begin
          d2_q     <= d2_q + 64'(mres_q);
          sq_v_q   <= d2_q + 64'(mres_q);
          sq_res_q <= '0;
          sq_bit_q <= 64'd1 << 62;
          ret_q <= S_ROOT; state_q <= S_SQRT;
        end
        S_ROOT: begin
          d_q   <= sq_res_q[31:0];
          sep_q <= sq_res_q[31:0];
          if (sq_res_q[31:0] == 32'd0) begin
            // coincident beads: no force
            tx_q <= '0; ty_q <= '0; idx_q <= '0;
            state_q <= S_DRIFT;
          end else begin
            dv_num_q <= {wmin_q, 33'd0}; dv_den_q <= {32'd0, sq_res_q[31:0]};
            dv_rem_q <= '0; dv_quo_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= DIV_RATIO;
            ret_q <= S_RATIO; state_q <= S_DIV;
          end
        end
        S_RATIO: begin
          qr_q     <= ratio_c;
          pw_q     <= {32'd0, ratio_c};
          lo_q     <= {32'd0, ratio_c};
          pw_cnt_q <= '0;
          if (wpow_q == 4'd0) begin
            state_q <= S_WELL;
          end else begin
            mm_q <= {32'd0, ratio_c}; mb_q <= ratio_c; mneg_q <= 1'b0;
            mraw_q <= 1'b0; msh16_q <= 1'b0;
            ret_q <= S_POW; state_q <= S_MUL_HI;
          end
        end
        S_POW: begin
          // one run of 2n products; q^(n+1) is picked off on the way
          pw_q     <= 64'(mres_q);
          pw_cnt_q <= pw_cnt_q + 5'd1;
          if (pw_cnt_q + 5'd1 == {1'b0, wpow_q}) begin
            lo_q <= 64'(mres_q);
          end
          if (pw_cnt_q + 5'd1 == {wpow_q, 1'b0}) begin
            state_q <= S_WELL;
          end else begin
            mm_q <= 64'(mres_q); mb_q <= qr_q; mneg_q <= 1'b0;
            mraw_q <= 1'b0; msh16_q <= 1'b0;
            ret_q <= S_POW; state_q <= S_MUL_HI;
          end
        end
        S_WELL: begin
          mm_q <= mag64(diff_c); mneg_q <= diff_c[63]; mb_q <= coeff_q;
          mraw_q <= 1'b0; msh16_q <= 1'b1;
          ret_q <= S_REP; state_q <= S_MUL_HI;
        end
        S_REP: begin
          u_q <= -mres_q;
          case (rep_kind_e'(rkind_q))
            REP_CONST: begin
              rep_q   <= {{24{rstr_q[31]}}, rstr_q, 8'd0};
              state_q <= S_SUM;
            end
            REP_LINEAR: begin
              mm_q <= {32'd0, s_mag}; mb_q <= d_q; mneg_q <= 1'b0; mraw_q <= 1'b1;
              ret_q <= S_REP_FIN; state_q <= S_MUL_LO;
            end
            REP_INV_SQ: begin
              dv_num_q <= {s_mag3, 30'd0}; dv_den_q <= d2_q;
              dv_rem_q <= '0; dv_quo_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= DIV_INVSQ;
              ret_q <= S_REP_FIN; state_q <= S_DIV;
            end
            REP_INV_CUBE: begin
              dv_num_q <= {s_mag2, 30'd0}; dv_den_q <= d2_q;
              dv_rem_q <= '0; dv_quo_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= DIV_INVSQ;
              ret_q <= S_REP_CUBE; state_q <= S_DIV;
            end
            default: begin
              rep_q   <= '0;
              state_q <= S_SUM;
            end
          endcase
        end
        S_REP_CUBE: begin
          dv_num_q <= {dres_q[61:0], 2'b00}; dv_den_q <= {32'd0, d_q};
          dv_rem_q <= '0; dv_quo_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= DIV_CHAIN;
          ret_q <= S_REP_FIN; state_q <= S_DIV;
        end
        S_REP_FIN: begin
          if (rkind_q == REP_LINEAR) begin
            rep_q <= rstr_q[31] ? -lin_c : lin_c;
          end else begin
            // inverse kinds push apart: negative for positive strength
            rep_q <= rstr_q[31] ? wide_t'(dres_q) : -wide_t'(dres_q);
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          u_q <= sat_lim(u_q + rep_q);
          dv_num_q <= {adx_q, 32'd0}; dv_den_q <= {32'd0, d_q};
          dv_rem_q <= '0; dv_quo_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= DIV_UNIT;
          ret_q <= S_UNIT_X; state_q <= S_DIV;
        end
        S_UNIT_X: begin
          mm_q <= mag64(u_q); mneg_q <= u_q[63]; mb_q <= dres_q[31:0];
          mraw_q <= 1'b0; msh16_q <= 1'b0;
          ret_q <= S_DIR_X; state_q <= S_MUL_HI;
        end
        S_DIR_X: begin
          tx_q <= dx_q[31] ? -mres_q : mres_q;
          dv_num_q <= {ady_q, 32'd0}; dv_den_q <= {32'd0, d_q};
          dv_rem_q <= '0; dv_quo_q <= '0; dv_sat_q <= 1'b0; dv_cnt_q <= DIV_UNIT;
          ret_q <= S_UNIT_Y; state_q <= S_DIV;
        end
        S_UNIT_Y: begin
          mm_q <= mag64(u_q); mneg_q <= u_q[63]; mb_q <= dres_q[31:0];
          mraw_q <= 1'b0; msh16_q <= 1'b0;
          ret_q <= S_DIR_Y; state_q <= S_MUL_HI;
        end
        S_DIR_Y: begin
          ty_q    <= dy_q[31] ? -mres_q : mres_q;
          idx_q   <= '0;
          state_q <= S_DRIFT;
        end
        S_DRIFT: begin
          mm_q <= mag64(f_sel); mneg_q <= f_sel[63];
          mb_q <= idx_q[1] ? drift2_q : drift1_q;
          mraw_q <= 1'b0; msh16_q <= 1'b1;
          ret_q <= S_DRIFT_FIN; state_q <= S_MUL_HI;
        end
        S_DRIFT_FIN: begin
          if (!stage_q) begin
            m1_q[idx_q] <= mres_q;
            ep_q[idx_q] <= mid_c[31:0];
          end else begin
            np_q[idx_q] <= fin_c[31:0];
          end
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            if (!stage_q) begin
              stage_q <= 1'b1;
              state_q <= S_DELTA;
            end else begin
              state_q <= S_FINISH;
            end
          end else begin
            state_q <= S_DRIFT;
          end
        end
        S_FINISH: begin
          // commit only once the previous result beat is gone
          if (!out_valid_q || out_ready_i) begin
            for (int i = 0; i < 4; i++) pos_q[i] <= np_q[i];
            time_q      <= time_sat_c;
            out_sep_q   <= sep_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_MUL_HI: begin
          hb_q    <= mult_p;
          state_q <= S_MUL_LO;
        end
        S_MUL_LO: begin
          lb_q    <= mult_p;
          state_q <= S_MUL_END;
        end
        S_MUL_END: begin
          mres_q  <= mc_res;
          state_q <= ret_q;
        end
        S_DIV: begin
          dv_rem_q <= dv_rem_n;
          dv_quo_q <= dv_quo_n;
          dv_sat_q <= dv_sat_n;
          dv_num_q <= dv_num_q << 1;
          dv_cnt_q <= dv_cnt_q - 7'd1;
          if (dv_cnt_q == 7'd1) begin
            dres_q  <= dv_fin;
            state_q <= ret_q;
          end
        end
        S_SQRT: begin
          sq_v_q   <= sq_v_n;
          sq_res_q <= sq_res_n;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            state_q <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pos_x_one_o    = pos_q[0];
  assign pos_y_one_o    = pos_q[1];
  assign pos_x_two_o    = pos_q[2];
  assign pos_y_two_o    = pos_q[3];
  assign elapsed_time_o = time_q;
  assign separation_o   = out_sep_q;

  // ---------------- assertions ----------------
  // After an accepted beat the sequencer is busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after an accepted beat");

  // Elapsed time saturates and never goes back
  a_time_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_time_o >= $past(elapsed_time_o))
    else $error("elapsed time decreased");

  // Positions only commit when the output slot is free
  a_commit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pos_x_one_o) |-> $past(!out_valid_o || out_ready_i))
    else $error("positions changed while a result beat was pending");

endmodule
